FILE: src/i2cbd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cbd_pkg
// Shared types, widths and the SCL divider table for the divider search.
// ----------------------------------------------------------------------------
package i2cbd_pkg;

  localparam int CLK_W   = 31;  // module clock, hertz
  localparam int TGT_W   = 22;  // wanted bus rate
  localparam int RATE_W  = 27;  // achieved rate
  localparam int IDX_W   = 6;
  localparam int MULT_W  = 2;
  localparam int BYTE_W  = 8;
  localparam int TAB_W   = 12;  // widest table entry is 3840
  localparam int DVS_W   = 14;  // table entry times four
  localparam int CNT_W   = 5;   // counts the CLK_W quotient bits

  localparam logic [IDX_W-1:0]  LAST_IDX   = 6'd63;
  localparam logic [MULT_W-1:0] LAST_MULT  = 2'd2;  // x4
  localparam int                MULT_SHIFT = 6;

  localparam logic [TAB_W-1:0] SCL_DIV [64] = '{
    12'd20,   12'd22,   12'd24,   12'd26,   12'd28,   12'd30,   12'd34,   12'd40,
    12'd28,   12'd32,   12'd36,   12'd40,   12'd44,   12'd48,   12'd56,   12'd68,
    12'd48,   12'd56,   12'd64,   12'd72,   12'd80,   12'd88,   12'd104,  12'd128,
    12'd80,   12'd96,   12'd112,  12'd128,  12'd144,  12'd160,  12'd192,  12'd240,
    12'd160,  12'd192,  12'd224,  12'd256,  12'd288,  12'd320,  12'd384,  12'd480,
    12'd320,  12'd384,  12'd448,  12'd512,  12'd576,  12'd640,  12'd768,  12'd960,
    12'd640,  12'd768,  12'd896,  12'd1024, 12'd1152, 12'd1280, 12'd1536, 12'd1920,
    12'd1280, 12'd1536, 12'd1792, 12'd2048, 12'd2304, 12'd2560, 12'd3072, 12'd3840
  };

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_WAIT,
    S_CMP,
    S_DONE
  } state_t;

  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

FILE: src/i2c_baud_divider_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_baud_divider_search
// Searches 64 SCL dividers x multipliers 1, 2, 4 for the closest bus rate.
// ----------------------------------------------------------------------------
// The 192 candidates are tried one after another: each starts the divider, waits for
//   done and is compared; the best pair is then loaded into the output registers.
// One request at a time: the bit-serial divider is shared by every candidate,
//   and the block is not ready while a search runs.
// Reset: synchronous, active low; clears the sequencer and out_valid.
module i2c_baud_divider_search
  import i2cbd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CLK_W-1:0]  in_module_clock_hz,
  input  logic [TGT_W-1:0]  in_target_rate,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [MULT_W-1:0] out_mult_code,
  output logic [IDX_W-1:0]  out_divider_index,
  output logic [RATE_W-1:0] out_achieved_rate,
  output logic [BYTE_W-1:0] out_divider_byte
);

  state_t state_r, state_nxt;

  logic [CLK_W-1:0]  clk_hz_r, clk_hz_nxt;
  logic [TGT_W-1:0]  tgt_r, tgt_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [MULT_W-1:0] mult_r, mult_nxt;
  logic [RATE_W-1:0] best_rate_r, best_rate_nxt;
  logic [RATE_W-1:0] best_err_r, best_err_nxt;
  logic [IDX_W-1:0]  best_idx_r, best_idx_nxt;
  logic [MULT_W-1:0] best_mult_r, best_mult_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [MULT_W-1:0] o_mult_r, o_mult_nxt;
  logic [IDX_W-1:0]  o_idx_r, o_idx_nxt;
  logic [RATE_W-1:0] o_rate_r, o_rate_nxt;

  div_ctl_t          div_ctl;
  div_stat_t         div_st;
  logic [CLK_W-1:0]  quo;
  logic [DVS_W-1:0]  divisor;
  logic [RATE_W-1:0] rate;
  logic [RATE_W-1:0] tgt_ext;
  logic [RATE_W-1:0] err;

  // multiplier is a power of two: shift the table entry
  assign divisor = DVS_W'({2'b00, SCL_DIV[idx_r]} << mult_r);

  i2cbd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (div_ctl),
    .dividend (clk_hz_r),
    .divisor  (divisor),
    .stat     (div_st),
    .quotient (quo)
  );

  // smallest divisor is 20, so the quotient fits RATE_W bits
  assign rate    = quo[RATE_W-1:0];
  assign tgt_ext = RATE_W'(tgt_r);
  assign err     = (tgt_ext >= rate) ? (tgt_ext - rate) : (rate - tgt_ext);

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    clk_hz_nxt    = clk_hz_r;
    tgt_nxt       = tgt_r;
    idx_nxt       = idx_r;
    mult_nxt      = mult_r;
    best_rate_nxt = best_rate_r;
    best_err_nxt  = best_err_r;
    best_idx_nxt  = best_idx_r;
    best_mult_nxt = best_mult_r;
    out_valid_nxt = out_valid_r;
    o_mult_nxt    = o_mult_r;
    o_idx_nxt     = o_idx_r;
    o_rate_nxt    = o_rate_r;
    div_ctl.start = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          clk_hz_nxt    = in_module_clock_hz;
          tgt_nxt       = in_target_rate;
          idx_nxt       = '0;
          mult_nxt      = '0;
          // notional best rate of zero: its error is the target itself
          best_rate_nxt = '0;
          best_err_nxt  = RATE_W'(in_target_rate);
          best_idx_nxt  = '0;
          best_mult_nxt = '0;
          state_nxt     = S_START;
        end
      end
      S_START: begin
        div_ctl.start = 1'b1;
        state_nxt     = S_WAIT;
      end
      S_WAIT: begin
        if (div_st.done) begin
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        // strict compare: ties keep the earlier pair
        if (err < best_err_r) begin
          best_err_nxt  = err;
          best_rate_nxt = rate;
          best_idx_nxt  = idx_r;
          best_mult_nxt = mult_r;
        end
        if (mult_r == LAST_MULT) begin
          mult_nxt = '0;
          idx_nxt  = idx_r + 1'b1;
        end else begin
          mult_nxt = mult_r + 1'b1;
        end
        if (mult_r == LAST_MULT && idx_r == LAST_IDX) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_START;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          o_mult_nxt    = best_mult_r;
          o_idx_nxt     = best_idx_r;
          o_rate_nxt    = best_rate_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    clk_hz_r    <= clk_hz_nxt;
    tgt_r       <= tgt_nxt;
    idx_r       <= idx_nxt;
    mult_r      <= mult_nxt;
    best_rate_r <= best_rate_nxt;
    best_err_r  <= best_err_nxt;
    best_idx_r  <= best_idx_nxt;
    best_mult_r <= best_mult_nxt;
    o_mult_r    <= o_mult_nxt;
    o_idx_r     <= o_idx_nxt;
    o_rate_r    <= o_rate_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_mult_code     = o_mult_r;
  assign out_divider_index = o_idx_r;
  assign out_achieved_rate = o_rate_r;
  assign out_divider_byte  = BYTE_W'({o_mult_r, o_idx_r});

  // ---- checks ----
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_ctl.start |-> !div_st.busy)
    else $error("divider started while busy");

  a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    div_st.busy |-> !in_ready)
    else $error("input ready during a division");

  a_mult_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_mult_code != 2'd3))
    else $error("illegal multiplier code on output");

  a_cmp_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP) |-> $past(div_st.done))
    else $error("compare without a finished division");

endmodule

FILE: src/i2cbd_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cbd_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module i2cbd_div
  import i2cbd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  div_ctl_t         ctl,
  input  logic [CLK_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output div_stat_t        stat,
  output logic [CLK_W-1:0] quotient
);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVS_W-1:0] dvs_r, dvs_nxt;
  logic [CLK_W-1:0] quo_r, quo_nxt;
  logic [DVS_W:0]   rem_sh;
  logic [DVS_W:0]   rem_sub;
  logic             ge;

  // dividend shifts out of the top of quo_r while quotient bits enter below
  assign rem_sh  = {rem_r, quo_r[CLK_W-1]};
  assign ge      = rem_sh >= {1'b0, dvs_r};
  assign rem_sub = rem_sh - {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    quo_nxt  = quo_r;
    if (ctl.start && !busy_r) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(CLK_W - 1);
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      quo_nxt  = dividend;
    end else if (busy_r) begin
      rem_nxt = ge ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
      quo_nxt = {quo_r[CLK_W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    quo_r <= quo_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;

endmodule
